// ===== src/clcd_pkg.sv =====
// Shared types, constants and the init command table for the character LCD sequencer.
package clcd_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLUMN_W = 6;
  localparam int unsigned ROW_W    = 2;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned STEP_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_QUARTER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_WRITE_US         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_HOLD_US      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_HOLD_US         = 2'd3;

  localparam logic [HOLD_W-1:0] COMMAND_HOLD_RESET = 16'd2000;
  localparam logic [HOLD_W-1:0] CHAR_HOLD_RESET    = 16'd50;

  localparam logic [BYTE_W-1:0] CMD_FUNCTION_SET = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON   = 8'h0E;
  localparam logic [BYTE_W-1:0] CMD_CLEAR        = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [BYTE_W-1:0] DDRAM_SET        = 8'h80;
  localparam logic [ADDR_W-1:0] LINE2_OFFSET     = 7'h40;
  localparam logic [ROW_W-1:0]  ROW_TWO          = 2'd2;

  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_CMD    = 2'd1,
    FUNC_CHAR   = 2'd2,
    FUNC_CURSOR = 2'd3
  } func_e;

  typedef struct packed {
    func_e             kind;
    logic [BYTE_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic [HOLD_W-1:0] command_hold_us;
    logic [HOLD_W-1:0] char_hold_us;
  } hold_cfg_t;

  function automatic logic [BYTE_W-1:0] init_byte(input logic [STEP_W-1:0] step);
    logic [BYTE_W-1:0] b;
    case (step)
      2'd0:    b = CMD_FUNCTION_SET;
      2'd1:    b = CMD_DISPLAY_ON;
      2'd2:    b = CMD_CLEAR;
      default: b = CMD_ENTRY_MODE;
    endcase
    return b;
  endfunction

endpackage

// ===== src/clcd_req_if.sv =====
// Request channel: one display request per word.
interface clcd_req_if import clcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [BYTE_W-1:0]   value;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;

  modport source (output valid, output func, output value, output column, output row,
                  input ready);
  modport sink   (input valid, input func, input value, input column, input row,
                  output ready);
endinterface

// ===== src/clcd_wr_if.sv =====
// Bus write channel: one display bus write per word.
interface clcd_wr_if import clcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              reg_select;
  logic [BYTE_W-1:0] bus_byte;
  logic              poll_first;
  logic [HOLD_W-1:0] hold_us;
  logic              last;

  modport source (output valid, output reg_select, output bus_byte, output poll_first,
                  output hold_us, output last, input ready);
  modport sink   (input valid, input reg_select, input bus_byte, input poll_first,
                  input hold_us, input last, output ready);
endinterface

// ===== src/clcd_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface clcd_cfg_if import clcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/char_lcd_command_sequencer_unit.sv =====
// Top level of the character LCD command sequencer.
// Each display request (init, command, character, cursor) becomes one to four bus write
// words, each with register select, data byte, a poll-busy flag and the hold time in
// microseconds to apply after the strobe. The front end classifies a request and computes
// the cursor address in the cycle it is taken; a queue of QUEUE_DEPTH jobs then feeds the
// back end, which issues one word per clock, unless the sink stalls, into a registered
// output stage. An init request expands into four words, every other request into one, so
// with a free sink the block sustains one word per cycle; the words' own display timing is
// applied by the downstream strobe engine. Configuration writes take effect on the next
// word issued and are always accepted.
module char_lcd_command_sequencer_unit import clcd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clcd_req_if.sink    req_i,
  clcd_wr_if.source   wr_o,
  clcd_cfg_if.sink    cfg_i
);

  hold_cfg_t hold_cfg;
  logic      q_push, q_full, q_pop, q_valid;
  job_t      push_job, head_job;

  clcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .hold_cfg_o (hold_cfg)
  );

  clcd_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (push_job)
  );

  clcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  clcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_cfg_i (hold_cfg),
    .q_valid_i  (q_valid),
    .q_job_i    (head_job),
    .q_pop_o    (q_pop),
    .wr_o       (wr_o)
  );

endmodule

// ===== src/clcd_cfg.sv =====
// Configuration registers: hold times after command and character writes.
module clcd_cfg import clcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clcd_cfg_if.sink   cfg_i,
  output hold_cfg_t  hold_cfg_o
);

  logic [HOLD_W-1:0] cmd_hold_q, char_hold_q;
  logic              wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // tick and pre-write registers belong to the strobe timing engine downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_hold_q  <= COMMAND_HOLD_RESET;
      char_hold_q <= CHAR_HOLD_RESET;
    end else if (wr_en) begin
      case (cfg_i.index)
        CFG_COMMAND_HOLD_US: cmd_hold_q  <= cfg_i.data;
        CFG_CHAR_HOLD_US:    char_hold_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign hold_cfg_o.command_hold_us = cmd_hold_q;
  assign hold_cfg_o.char_hold_us    = char_hold_q;

endmodule

// ===== src/clcd_front.sv =====
// Front end: accepts requests, classifies them and builds the queued job.
module clcd_front import clcd_pkg::*; (
  clcd_req_if.sink  req_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output job_t      q_job_o
);

  logic [ADDR_W-1:0] addr;

  assign req_i.ready = !q_full_i;
  assign q_push_o    = req_i.valid && !q_full_i;

  always_comb begin
    addr = ADDR_W'(req_i.column) - ADDR_W'(1);
    if (req_i.row == ROW_TWO) begin
      addr = addr + LINE2_OFFSET;
    end
    q_job_o.kind = func_e'(req_i.func);
    case (func_e'(req_i.func))
      FUNC_CURSOR: q_job_o.data = DDRAM_SET | BYTE_W'(addr);
      default:     q_job_o.data = req_i.value;
    endcase
  end

endmodule

// ===== src/clcd_queue.sv =====
// Short job queue between front and back ends.
module clcd_queue import clcd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t              mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== src/clcd_back.sv =====
// Back end: expands queued jobs into bus write words behind an output register.
module clcd_back import clcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hold_cfg_t  hold_cfg_i,
  input  logic       q_valid_i,
  input  job_t       q_job_i,
  output logic       q_pop_o,
  clcd_wr_if.source  wr_o
);

  logic              out_valid_q;
  logic              rs_q, poll_q, last_q;
  logic [BYTE_W-1:0] byte_q;
  logic [HOLD_W-1:0] hold_q;
  logic [STEP_W-1:0] step_q;

  logic              load, fire, is_last;
  logic              rs_d, poll_d;
  logic [BYTE_W-1:0] byte_d;
  logic [HOLD_W-1:0] hold_d;

  always_comb begin
    load    = !out_valid_q || wr_o.ready;
    fire    = load && q_valid_i;
    is_last = (q_job_i.kind != FUNC_INIT) || (step_q == INIT_LAST_STEP);
    q_pop_o = fire && is_last;
    rs_d    = 1'b0;
    poll_d  = 1'b1;
    byte_d  = q_job_i.data;
    hold_d  = hold_cfg_i.command_hold_us;
    case (q_job_i.kind)
      FUNC_INIT:   byte_d = init_byte(step_q);
      FUNC_CMD:    ;
      FUNC_CHAR: begin
        rs_d   = 1'b1;
        hold_d = hold_cfg_i.char_hold_us;
      end
      FUNC_CURSOR: begin
        poll_d = 1'b0;
        hold_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rs_q   <= rs_d;
      byte_q <= byte_d;
      poll_q <= poll_d;
      hold_q <= hold_d;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= q_valid_i;
      end
      if (fire) begin
        step_q <= is_last ? '0 : step_q + STEP_W'(1);
      end
    end
  end

  assign wr_o.valid      = out_valid_q;
  assign wr_o.reg_select = rs_q;
  assign wr_o.bus_byte   = byte_q;
  assign wr_o.poll_first = poll_q;
  assign wr_o.hold_us    = hold_q;
  assign wr_o.last       = last_q;

endmodule
